[rtl/core/cmbx_pkg.sv]
// Package for the miscellaneous and branch execute unit.
// Holds the command codes, flag bit positions, DAA constants and SP/PC constants. No dependencies.
package cmbx_pkg;

  // Instruction codes carried in the cmd field
  typedef enum logic [3:0] {
    CMD_NOP  = 4'd0,
    CMD_HALT = 4'd1,
    CMD_STOP = 4'd2,
    CMD_DI   = 4'd3,
    CMD_EI   = 4'd4,
    CMD_DAA  = 4'd5,
    CMD_JP   = 4'd6,
    CMD_JR   = 4'd7,
    CMD_CALL = 4'd8,
    CMD_RST  = 4'd9,
    CMD_RET  = 4'd10,
    CMD_RLCA = 4'd11,
    CMD_RLA  = 4'd12,
    CMD_RRA  = 4'd13,
    CMD_RRCA = 4'd14
  } cmd_t;

  // Flag bit positions in the 4-bit flag word
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [8:0] DAA_HI_LIMIT = 9'h09F;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  localparam logic [15:0] SP_RESET = 16'hFFFE;
  localparam logic [15:0] PC_STEP  = 16'd2;

endpackage

[rtl/core/cmbx_if.sv]
// Channel interfaces for the miscellaneous and branch execute unit.
// Depends on cmbx_pkg (command width).
interface cmbx_in_if;
  import cmbx_pkg::*;

  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [1:0]  cond_flag;
  logic        cond_value;
  logic        use_cond;
  logic [15:0] operand_word;

  modport source (output valid, cmd, cond_flag, cond_value, use_cond, operand_word,
                  input ready);
  modport sink   (input valid, cmd, cond_flag, cond_value, use_cond, operand_word,
                  output ready);
endinterface

interface cmbx_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic [3:0]  flags_out;
  logic [15:0] pc_out;
  logic [15:0] sp_out;
  logic        push_valid;
  logic [15:0] push_value;
  logic        halted;
  logic        stopped;
  logic        irq_disable_pending;
  logic        irq_enable_pending;

  modport source (output valid, acc_out, flags_out, pc_out, sp_out, push_valid,
                  push_value, halted, stopped, irq_disable_pending, irq_enable_pending,
                  input ready);
  modport sink   (input valid, acc_out, flags_out, pc_out, sp_out, push_valid,
                  push_value, halted, stopped, irq_disable_pending, irq_enable_pending,
                  output ready);
endinterface

[rtl/core/cpu_misc_and_branch_execute_unit.sv]
// Top level of the miscellaneous and branch execute unit.
// Depends on cmbx_pkg and the channel interfaces in cmbx_if.sv.
//
// Executes one miscellaneous or branch instruction of an 8-bit CPU per input beat
// (nop, halt, stop, di, ei, daa, jp, jr, call, rst, ret and the four accumulator
// rotates) against the architectural state held here: accumulator, Z/N/H/C flags,
// PC, SP, halt/stop latches and the pending interrupt disable/enable marks. Every
// input beat yields exactly one result beat carrying the state after the
// instruction plus an optional stack push (call/rst). Throughput is one instruction
// per cycle unless stalled: the next state is a single pass of short adders and
// muxes over the state registers, and the state registers double as the result
// register, so the result is valid in the cycle after accept. The input is ready
// whenever the result register is empty or is being drained in the same cycle.
// Immediate operands and popped return addresses arrive in operand_word; the
// caller does the stack memory access itself using push_value / sp_out.
module cpu_misc_and_branch_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  cmbx_in_if.sink     in_ch,
  cmbx_out_if.source  out_ch
);
  import cmbx_pkg::*;

  // Architectural state; doubles as the result register
  logic [7:0]  acc_r,   acc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [15:0] pc_r,    pc_nxt;
  logic [15:0] sp_r,    sp_nxt;
  logic        halt_r,  halt_nxt;
  logic        stop_r,  stop_nxt;
  logic        dis_r,   dis_nxt;
  logic        en_r,    en_nxt;

  // Per-beat result fields
  logic        out_valid_r;
  logic        push_valid_r, push_valid_nxt;
  logic [15:0] push_value_r, push_value_nxt;

  logic        in_beat;
  logic        taken;

  // DAA datapath
  logic        daa_adj_lo;
  logic        daa_adj_hi;
  logic [8:0]  daa_sum;
  logic [7:0]  daa_add_acc;
  logic [7:0]  daa_sub_acc;
  logic [7:0]  daa_acc;
  logic        daa_c;

  logic [15:0] jr_offset;

  // Result slot frees up this cycle if empty or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;

  // Condition: flag index runs Z,N,H,C from bit 3 down, hence the inversion
  assign taken = !in_ch.use_cond || (flags_r[~in_ch.cond_flag] == in_ch.cond_value);

  // Decimal adjust, add mode: low fix, then high fix on the widened sum
  assign daa_adj_lo  = flags_r[FLAG_H] || (acc_r[3:0] > DAA_LO_LIMIT);
  assign daa_sum     = {1'b0, acc_r} + {1'b0, (daa_adj_lo ? DAA_LO_ADJ : 8'h00)};
  assign daa_adj_hi  = flags_r[FLAG_C] || (daa_sum > DAA_HI_LIMIT);
  assign daa_add_acc = daa_sum[7:0] + (daa_adj_hi ? DAA_HI_ADJ : 8'h00);
  // Subtract mode: undo by H and C, carry left alone
  assign daa_sub_acc = acc_r - (flags_r[FLAG_H] ? DAA_LO_ADJ : 8'h00)
                             - (flags_r[FLAG_C] ? DAA_HI_ADJ : 8'h00);
  assign daa_acc     = flags_r[FLAG_N] ? daa_sub_acc : daa_add_acc;
  assign daa_c       = flags_r[FLAG_N] ? flags_r[FLAG_C] : daa_adj_hi;

  assign jr_offset = {{8{in_ch.operand_word[7]}}, in_ch.operand_word[7:0]};

  always_comb begin
    acc_nxt        = acc_r;
    flags_nxt      = flags_r;
    pc_nxt         = pc_r;
    sp_nxt         = sp_r;
    halt_nxt       = halt_r;
    stop_nxt       = stop_r;
    dis_nxt        = dis_r;
    en_nxt         = en_r;
    push_valid_nxt = 1'b0;
    push_value_nxt = 16'h0000;

    unique case (in_ch.cmd)
      CMD_NOP:  ;
      CMD_HALT: halt_nxt = 1'b1;
      CMD_STOP: stop_nxt = 1'b1;
      CMD_DI:   dis_nxt  = 1'b1;
      CMD_EI:   en_nxt   = 1'b1;
      CMD_DAA: begin
        acc_nxt           = daa_acc;
        flags_nxt[FLAG_Z] = (daa_acc == 8'h00);
        flags_nxt[FLAG_H] = 1'b0;
        flags_nxt[FLAG_C] = daa_c;
      end
      CMD_JP: begin
        pc_nxt = taken ? in_ch.operand_word : pc_r + PC_STEP;
      end
      CMD_JR: begin
        pc_nxt = pc_r + 16'd1 + (taken ? jr_offset : 16'h0000);
      end
      CMD_CALL: begin
        if (taken) begin
          sp_nxt         = sp_r - PC_STEP;
          push_valid_nxt = 1'b1;
          push_value_nxt = pc_r + PC_STEP;
          pc_nxt         = in_ch.operand_word;
        end else begin
          pc_nxt = pc_r + PC_STEP;
        end
      end
      CMD_RST: begin
        sp_nxt         = sp_r - PC_STEP;
        push_valid_nxt = 1'b1;
        push_value_nxt = pc_r;
        pc_nxt         = {8'h00, in_ch.operand_word[7:0]};
      end
      CMD_RET: begin
        if (taken) begin
          pc_nxt = in_ch.operand_word;
          sp_nxt = sp_r + PC_STEP;
        end
      end
      // Rotates clear all flags; C takes the bit shifted out
      CMD_RLCA: begin
        flags_nxt = {3'b000, acc_r[7]};
        acc_nxt   = {acc_r[6:0], acc_r[7]};
      end
      CMD_RLA: begin
        flags_nxt = {3'b000, acc_r[7]};
        acc_nxt   = {acc_r[6:0], flags_r[FLAG_C]};
      end
      CMD_RRA: begin
        flags_nxt = {3'b000, acc_r[0]};
        acc_nxt   = {flags_r[FLAG_C], acc_r[7:1]};
      end
      CMD_RRCA: begin
        flags_nxt = {3'b000, acc_r[0]};
        acc_nxt   = {acc_r[0], acc_r[7:1]};
      end
      default: ; // unused code behaves as nop
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= 8'h00;
      flags_r      <= 4'h0;
      pc_r         <= 16'h0000;
      sp_r         <= SP_RESET;
      halt_r       <= 1'b0;
      stop_r       <= 1'b0;
      dis_r        <= 1'b0;
      en_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      push_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        acc_r        <= acc_nxt;
        flags_r      <= flags_nxt;
        pc_r         <= pc_nxt;
        sp_r         <= sp_nxt;
        halt_r       <= halt_nxt;
        stop_r       <= stop_nxt;
        dis_r        <= dis_nxt;
        en_r         <= en_nxt;
        push_valid_r <= push_valid_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Push payload carries no reset; it is zero whenever a result without a push is valid
  always_ff @(posedge clk) begin
    if (in_beat) begin
      push_value_r <= push_value_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.acc_out             = acc_r;
  assign out_ch.flags_out           = flags_r;
  assign out_ch.pc_out              = pc_r;
  assign out_ch.sp_out              = sp_r;
  assign out_ch.push_valid          = push_valid_r;
  assign out_ch.push_value          = push_value_r;
  assign out_ch.halted              = halt_r;
  assign out_ch.stopped             = stop_r;
  assign out_ch.irq_disable_pending = dis_r;
  assign out_ch.irq_enable_pending  = en_r;

  // Assertions
  a_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !push_valid_r) |-> (push_value_r == 16'h0000))
    else $error("push value not zero without a push");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt latch cleared");

  a_rst_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_ch.cmd == CMD_RST) |=>
      (push_valid_r && sp_r == $past(sp_r) - PC_STEP))
    else $error("rst did not push and drop sp by two");

  a_daa_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_ch.cmd == CMD_DAA) |=>
      (flags_r[FLAG_Z] == (acc_r == 8'h00) && !flags_r[FLAG_H]))
    else $error("daa zero or half-carry flag wrong");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while result stalled");

endmodule
